### src/lob_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lob_pkg;

    localparam int MAX_ORDERS_DEF = 64;
    localparam int PRICE_BITS_DEF = 16;
    localparam int QTY_BITS_DEF   = 32;
    localparam int MAX_RESULTS    = 64;
    localparam int ID_BITS        = 32;
    localparam int ARR_BITS       = 32;
    localparam int OUTCOME_BITS   = 4;
    localparam int KIND_BITS      = 2;
    localparam int K_BITS         = $clog2(MAX_RESULTS + 1);

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_CANCEL = 1'b1;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic [KIND_BITS-1:0] KIND_LIMIT  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_MARKET = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_FAK    = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_FOK    = 2'd3;

    localparam logic [OUTCOME_BITS-1:0] OUT_FILLED    = 4'd0;
    localparam logic [OUTCOME_BITS-1:0] OUT_RESTED    = 4'd1;
    localparam logic [OUTCOME_BITS-1:0] OUT_DUPLICATE = 4'd2;
    localparam logic [OUTCOME_BITS-1:0] OUT_MKT_EMPTY = 4'd3;
    localparam logic [OUTCOME_BITS-1:0] OUT_FAK_FAIL  = 4'd4;
    localparam logic [OUTCOME_BITS-1:0] OUT_FOK_FAIL  = 4'd5;
    localparam logic [OUTCOME_BITS-1:0] OUT_BOOK_FULL = 4'd6;
    localparam logic [OUTCOME_BITS-1:0] OUT_CANCELLED = 4'd7;
    localparam logic [OUTCOME_BITS-1:0] OUT_UNKNOWN   = 4'd8;

endpackage
`default_nettype wire

### src/limit_order_book_matcher.sv
// A cancel or reject walks the book once to look up the id, then loads its status word.
// An add makes the same id walk, then walks the book once per trade, plus one more walk
// when a remainder is left, before its final word is loaded.
// Words are taken one at a time; the next word is taken once the last result is loaded.
// Each walk reads the single-read book memory one entry per cycle.
// Reset (synchronous, active low) clears entry valid bits, arrival counter, FSM, output valid.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_matcher #(
    parameter int MAX_ORDERS = lob_pkg::MAX_ORDERS_DEF,
    parameter int PRICE_BITS = lob_pkg::PRICE_BITS_DEF,
    parameter int QTY_BITS   = lob_pkg::QTY_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_mode,
    input  wire logic [lob_pkg::ID_BITS-1:0]       i_order_id,
    input  wire logic                              i_side,
    input  wire logic [lob_pkg::KIND_BITS-1:0]     i_order_kind,
    input  wire logic [PRICE_BITS-1:0]             i_limit_price,
    input  wire logic [QTY_BITS-1:0]               i_quantity,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_trade_valid,
    output logic [PRICE_BITS-1:0]                  o_trade_price,
    output logic [QTY_BITS-1:0]                    o_trade_quantity,
    output logic [lob_pkg::ID_BITS-1:0]            o_resting_id,
    output logic [lob_pkg::ID_BITS-1:0]            o_incoming_id,
    output logic [lob_pkg::OUTCOME_BITS-1:0]       o_outcome,
    output logic                                   o_last
);

    localparam int AW  = $clog2(MAX_ORDERS);
    localparam int IW  = AW + 1;
    localparam int IDB = lob_pkg::ID_BITS;
    localparam int ARB = lob_pkg::ARR_BITS;
    localparam int KB  = lob_pkg::K_BITS;
    localparam int OB  = lob_pkg::OUTCOME_BITS;
    localparam int SW  = QTY_BITS + AW + 1;
    localparam int WW  = IDB + 1 + PRICE_BITS + QTY_BITS + ARB;
    localparam int REM_LO = ARB;
    localparam int PR_LO  = ARB + QTY_BITS;
    localparam int SD_POS = ARB + QTY_BITS + PRICE_BITS;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_SEARCH = 7'b0001000,
        S_EMIT   = 7'b0010000,
        S_APPLY  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [MAX_ORDERS-1:0] r_valid, n_valid;
    logic [ARB-1:0]        r_cnt, n_cnt;
    logic                  r_ovalid, n_ovalid;

    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_dv, n_dv;
    logic [AW-1:0]         r_didx, n_didx;

    logic                  r_mode, n_mode;
    logic [IDB-1:0]        r_id, n_id;
    logic                  r_side, n_side;
    logic [1:0]            r_kind, n_kind;
    logic [PRICE_BITS-1:0] r_lim, n_lim;
    logic [QTY_BITS-1:0]   r_rem, n_rem;

    logic                  r_found, n_found;
    logic [AW-1:0]         r_found_idx, n_found_idx;
    logic                  r_wany, n_wany;
    logic [PRICE_BITS-1:0] r_worst, n_worst;
    logic                  r_xany, n_xany;
    logic [SW-1:0]         r_sum, n_sum;

    logic                  r_bany, n_bany;
    logic [AW-1:0]         r_bidx, n_bidx;
    logic [WW-1:0]         r_bword, n_bword;
    logic [ARB-1:0]        r_bage, n_bage;
    logic                  r_free_ok, n_free_ok;
    logic [AW-1:0]         r_free, n_free;
    logic [KB-1:0]         r_k, n_k;

    logic                  r_pend, n_pend;
    logic [PRICE_BITS-1:0] r_pprice, n_pprice;
    logic [QTY_BITS-1:0]   r_pqty, n_pqty;
    logic [IDB-1:0]        r_prid, n_prid;

    logic                  n_otv, n_olast;
    logic [PRICE_BITS-1:0] n_oprice;
    logic [QTY_BITS-1:0]   n_oqty;
    logic [IDB-1:0]        n_orid, n_oiid;
    logic [OB-1:0]         n_oout;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [WW-1:0]         w_wdata;
    logic [WW-1:0]         w_rdata;

    logic                  e_valid, e_side, e_opp, e_cross, can_load, scan_done, better;
    logic [IDB-1:0]        e_id;
    logic [PRICE_BITS-1:0] e_price, b_price;
    logic [QTY_BITS-1:0]   e_rem, b_rem, q, b_newrem;
    logic [ARB-1:0]        e_arr, e_age;

    lob_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_ORDERS)
    ) u_book (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        e_id    = w_rdata[WW-1 -: IDB];
        e_side  = w_rdata[SD_POS];
        e_price = w_rdata[PR_LO +: PRICE_BITS];
        e_rem   = w_rdata[REM_LO +: QTY_BITS];
        e_arr   = w_rdata[ARB-1:0];
        e_valid = r_dv && r_valid[r_didx];
        e_opp   = (e_side != r_side);
        e_cross = (r_side == lob_pkg::SIDE_BUY) ? (e_price <= r_lim) : (e_price >= r_lim);
        e_age   = r_cnt - e_arr;
        b_price = r_bword[PR_LO +: PRICE_BITS];
        b_rem   = r_bword[REM_LO +: QTY_BITS];
        q        = (r_rem < b_rem) ? r_rem : b_rem;
        b_newrem = b_rem - q;
        better  = !r_bany
                  || ((r_side == lob_pkg::SIDE_BUY) ? (e_price < b_price) : (e_price > b_price))
                  || (e_price == b_price && e_age > r_bage);
        can_load  = !r_ovalid || i_out_ready;
        scan_done = (r_idx == IW'(MAX_ORDERS)) && !r_dv;
    end

    always_comb begin
        n_state = r_state;     n_valid = r_valid;     n_cnt = r_cnt;
        n_ovalid = r_ovalid && !i_out_ready;
        n_idx = r_idx;         n_dv = 1'b0;           n_didx = r_didx;
        n_mode = r_mode;       n_id = r_id;           n_side = r_side;
        n_kind = r_kind;       n_lim = r_lim;         n_rem = r_rem;
        n_found = r_found;     n_found_idx = r_found_idx;
        n_wany = r_wany;       n_worst = r_worst;     n_xany = r_xany;  n_sum = r_sum;
        n_bany = r_bany;       n_bidx = r_bidx;       n_bword = r_bword; n_bage = r_bage;
        n_free_ok = r_free_ok; n_free = r_free;       n_k = r_k;
        n_pend = r_pend;       n_pprice = r_pprice;   n_pqty = r_pqty;  n_prid = r_prid;
        n_otv = o_trade_valid; n_oprice = o_trade_price; n_oqty = o_trade_quantity;
        n_orid = o_resting_id; n_oiid = o_incoming_id; n_oout = o_outcome;
        n_olast = o_last;
        w_we = 1'b0;           w_waddr = r_bidx;      w_wdata = r_bword;

        if ((r_state == S_SCAN || r_state == S_SEARCH) && r_idx != IW'(MAX_ORDERS)) begin
            n_idx  = r_idx + IW'(1);
            n_dv   = 1'b1;
            n_didx = r_idx[AW-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode = i_mode;   n_id = i_order_id;   n_side = i_side;
                    n_kind = i_order_kind; n_lim = i_limit_price; n_rem = i_quantity;
                    n_found = 1'b0; n_wany = 1'b0; n_xany = 1'b0; n_sum = '0;
                    n_k = '0; n_pend = 1'b0;
                    n_idx = '0; n_dv = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (e_valid) begin
                    if (e_id == r_id && !r_found) begin
                        n_found = 1'b1;
                        n_found_idx = r_didx;
                    end
                    if (e_opp) begin
                        if (!r_wany || ((r_side == lob_pkg::SIDE_BUY) ? (e_price > r_worst)
                                                                       : (e_price < r_worst))) begin
                            n_worst = e_price;
                        end
                        n_wany = 1'b1;
                        if (e_cross) begin
                            n_xany = 1'b1;
                            n_sum  = r_sum + SW'(e_rem);
                        end
                    end
                end
                if (scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_otv = 1'b0; n_oprice = '0; n_oqty = '0; n_orid = '0;
                n_oiid = r_id; n_olast = 1'b1;
                n_idx = '0; n_dv = 1'b0; n_bany = 1'b0; n_free_ok = 1'b0;
                if (r_mode == lob_pkg::MODE_CANCEL) begin
                    n_oout = r_found ? lob_pkg::OUT_CANCELLED : lob_pkg::OUT_UNKNOWN;
                end else if (r_found) begin
                    n_oout = lob_pkg::OUT_DUPLICATE;
                end else if (r_rem == '0) begin
                    n_oout = lob_pkg::OUT_FILLED;
                end else if (r_kind == lob_pkg::KIND_MARKET && !r_wany) begin
                    n_oout = lob_pkg::OUT_MKT_EMPTY;
                end else if (r_kind == lob_pkg::KIND_FAK && !r_xany) begin
                    n_oout = lob_pkg::OUT_FAK_FAIL;
                end else if (r_kind == lob_pkg::KIND_FOK && r_sum < SW'(r_rem)) begin
                    n_oout = lob_pkg::OUT_FOK_FAIL;
                end else begin
                    n_oout = o_outcome;
                end
                if (r_mode == lob_pkg::MODE_ADD && !r_found && r_rem != '0
                    && !(r_kind == lob_pkg::KIND_MARKET && !r_wany)
                    && !(r_kind == lob_pkg::KIND_FAK && !r_xany)
                    && !(r_kind == lob_pkg::KIND_FOK && r_sum < SW'(r_rem))) begin
                    n_otv = o_trade_valid; n_oprice = o_trade_price; n_oqty = o_trade_quantity;
                    n_orid = o_resting_id; n_oiid = o_incoming_id; n_olast = o_last;
                    if (r_kind == lob_pkg::KIND_MARKET) begin
                        n_lim = r_worst;
                    end
                    n_state = S_SEARCH;
                end else if (can_load) begin
                    n_ovalid = 1'b1;
                    if (r_mode == lob_pkg::MODE_CANCEL && r_found) begin
                        n_valid[r_found_idx] = 1'b0;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_otv = o_trade_valid; n_oprice = o_trade_price; n_oqty = o_trade_quantity;
                    n_orid = o_resting_id; n_oiid = o_incoming_id; n_oout = o_outcome;
                    n_olast = o_last;
                end
            end
            S_SEARCH: begin
                if (r_dv && !r_valid[r_didx] && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free = r_didx;
                end
                if (e_valid && e_opp && e_cross && better) begin
                    n_bany = 1'b1;
                    n_bidx = r_didx;
                    n_bword = w_rdata;
                    n_bage = e_age;
                end
                if (scan_done) begin
                    if (r_bany && r_k != KB'(lob_pkg::MAX_RESULTS)) begin
                        n_state = r_pend ? S_EMIT : S_APPLY;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_EMIT: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_otv = 1'b1; n_oprice = r_pprice; n_oqty = r_pqty; n_orid = r_prid;
                    n_oiid = r_id; n_oout = lob_pkg::OUT_FILLED; n_olast = 1'b0;
                    n_pend = 1'b0;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_pend = 1'b1;
                n_pprice = b_price;
                n_pqty = q;
                n_prid = r_bword[WW-1 -: IDB];
                w_we = 1'b1;
                w_waddr = r_bidx;
                w_wdata = r_bword;
                w_wdata[REM_LO +: QTY_BITS] = b_newrem;
                if (b_newrem == '0) begin
                    n_valid[r_bidx] = 1'b0;
                end
                n_rem = r_rem - q;
                n_k = r_k + KB'(1);
                n_idx = '0; n_dv = 1'b0; n_bany = 1'b0; n_free_ok = 1'b0;
                n_state = (r_rem - q != '0) ? S_SEARCH : S_FINISH;
            end
            S_FINISH: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_oout = lob_pkg::OUT_FILLED;
                    if (r_rem != '0 && r_kind != lob_pkg::KIND_FAK) begin
                        if (r_free_ok) begin
                            w_we = 1'b1;
                            w_waddr = r_free;
                            w_wdata = {r_id, r_side, r_lim, r_rem, r_cnt};
                            n_valid[r_free] = 1'b1;
                            n_cnt = r_cnt + ARB'(1);
                            n_oout = lob_pkg::OUT_RESTED;
                        end else begin
                            n_oout = lob_pkg::OUT_BOOK_FULL;
                        end
                    end
                    n_otv = r_pend;
                    n_oprice = r_pend ? r_pprice : '0;
                    n_oqty = r_pend ? r_pqty : '0;
                    n_orid = r_pend ? r_prid : '0;
                    n_oiid = r_id;
                    n_olast = 1'b1;
                    n_pend = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;  r_dv <= n_dv;  r_didx <= n_didx;
        r_mode <= n_mode; r_id <= n_id; r_side <= n_side; r_kind <= n_kind;
        r_lim <= n_lim;  r_rem <= n_rem;
        r_found <= n_found; r_found_idx <= n_found_idx;
        r_wany <= n_wany; r_worst <= n_worst; r_xany <= n_xany; r_sum <= n_sum;
        r_bany <= n_bany; r_bidx <= n_bidx; r_bword <= n_bword; r_bage <= n_bage;
        r_free_ok <= n_free_ok; r_free <= n_free; r_k <= n_k;
        r_pend <= n_pend; r_pprice <= n_pprice; r_pqty <= n_pqty; r_prid <= n_prid;
        o_trade_valid <= n_otv; o_trade_price <= n_oprice; o_trade_quantity <= n_oqty;
        o_resting_id <= n_orid; o_incoming_id <= n_oiid; o_outcome <= n_oout;
        o_last <= n_olast;
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_trade_valid) |-> o_last)
        else $error("status word without last");

    a_outcome_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_outcome == lob_pkg::OUT_FILLED))
        else $error("outcome set on non-final word");

    a_apply_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> (r_bany && r_k != KB'(lob_pkg::MAX_RESULTS)))
        else $error("apply without a matched entry");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_SCAN))
        else $error("accepted word did not start id scan");

endmodule
`default_nettype wire

### src/lob_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### tb/tb_limit_order_book_matcher.sv
`timescale 1ns / 1ps
module tb_limit_order_book_matcher;

    localparam int NORD = 64;
    localparam int CYCLE_LIMIT = 15000000;

    typedef struct packed {
        logic        mode;
        logic [31:0] id;
        logic        side;
        logic [1:0]  kind;
        logic [15:0] price;
        logic [31:0] qty;
    } t_order_word;

    typedef struct packed {
        logic        tv;
        logic [15:0] tp;
        logic [31:0] tq;
        logic [31:0] rid;
        logic [31:0] iid;
        logic [3:0]  outcome;
        logic        last;
    } t_trade_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_mode = 1'b0;
    logic [31:0] i_order_id = '0;
    logic i_side = 1'b0;
    logic [1:0] i_order_kind = '0;
    logic [15:0] i_limit_price = '0;
    logic [31:0] i_quantity = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_trade_valid;
    logic [15:0] o_trade_price;
    logic [31:0] o_trade_quantity;
    logic [31:0] o_resting_id;
    logic [31:0] o_incoming_id;
    logic [3:0] o_outcome;
    logic o_last;

    limit_order_book_matcher u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_mode(i_mode), .i_order_id(i_order_id), .i_side(i_side),
        .i_order_kind(i_order_kind), .i_limit_price(i_limit_price),
        .i_quantity(i_quantity),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_trade_valid(o_trade_valid), .o_trade_price(o_trade_price),
        .o_trade_quantity(o_trade_quantity), .o_resting_id(o_resting_id),
        .o_incoming_id(o_incoming_id), .o_outcome(o_outcome), .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // book shadow
    logic        bk_valid [NORD];
    logic [31:0] bk_id    [NORD];
    logic        bk_side  [NORD];
    logic [15:0] bk_price [NORD];
    logic [31:0] bk_rem   [NORD];
    logic [31:0] bk_arr   [NORD];
    logic [31:0] arr_cnt;

    t_order_word pending_orders[$];
    t_trade_word expected_trades[$];
    int errors = 0;
    bit no_idle = 1'b0;
    bit hold_send = 1'b0;
    int cycles = 0;
    int in_gap = 0;
    int out_gap = 0;

    function automatic void queue_order(t_order_word w);
        pending_orders = {pending_orders, w};
    endfunction

    function automatic void queue_expect(t_trade_word t);
        expected_trades = {expected_trades, t};
    endfunction

    task automatic wait_sent();
        do @(negedge i_clk); while (pending_orders.size() != 0 || i_in_valid);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (expected_trades.size() != 0);
    endtask

    function automatic bit crosses(logic s, logic [15:0] lim, logic [15:0] p);
        return s == lob_pkg::SIDE_BUY ? p <= lim : p >= lim;
    endfunction

    function automatic int best_opposite(logic s, logic [15:0] lim);
        int best;
        logic [31:0] best_age, age;
        logic better;
        best = -1;
        best_age = 0;
        for (int i = 0; i < NORD; i++) begin
            if (!bk_valid[i] || bk_side[i] == s) continue;
            if (!crosses(s, lim, bk_price[i])) continue;
            age = arr_cnt - bk_arr[i];
            if (best < 0) begin
                best = i;
                best_age = age;
                continue;
            end
            better = (s == lob_pkg::SIDE_BUY) ? bk_price[i] < bk_price[best]
                                              : bk_price[i] > bk_price[best];
            if (better || (bk_price[i] == bk_price[best] && age > best_age)) begin
                best = i;
                best_age = age;
            end
        end
        return best;
    endfunction

    function automatic void push_status(logic [31:0] id, logic [3:0] oc);
        t_trade_word t;
        t = '0;
        t.iid = id;
        t.outcome = oc;
        t.last = 1'b1;
        queue_expect(t);
    endfunction

    function automatic void match_order(t_order_word w);
        int found, wi, b, f, k;
        logic [15:0] lim;
        logic [31:0] rem, q;
        logic [63:0] sum;
        logic [3:0] oc;
        t_trade_word t;
        found = -1;
        lim = w.price;
        rem = w.qty;
        for (int i = 0; i < NORD; i++)
            if (found < 0 && bk_valid[i] && bk_id[i] == w.id) found = i;
        if (w.mode == lob_pkg::MODE_CANCEL) begin
            if (found >= 0) bk_valid[found] = 1'b0;
            push_status(w.id, found >= 0 ? lob_pkg::OUT_CANCELLED : lob_pkg::OUT_UNKNOWN);
            return;
        end
        if (found >= 0) begin
            push_status(w.id, lob_pkg::OUT_DUPLICATE);
            return;
        end
        if (rem == 0) begin
            push_status(w.id, lob_pkg::OUT_FILLED);
            return;
        end
        if (w.kind == lob_pkg::KIND_MARKET) begin
            wi = -1;
            for (int i = 0; i < NORD; i++) begin
                if (!bk_valid[i] || bk_side[i] == w.side) continue;
                if (wi < 0 || (w.side == lob_pkg::SIDE_BUY ? bk_price[i] > bk_price[wi]
                                                          : bk_price[i] < bk_price[wi]))
                    wi = i;
            end
            if (wi < 0) begin
                push_status(w.id, lob_pkg::OUT_MKT_EMPTY);
                return;
            end
            lim = bk_price[wi];
        end else if (w.kind == lob_pkg::KIND_FAK) begin
            if (best_opposite(w.side, lim) < 0) begin
                push_status(w.id, lob_pkg::OUT_FAK_FAIL);
                return;
            end
        end else if (w.kind == lob_pkg::KIND_FOK) begin
            sum = 0;
            for (int i = 0; i < NORD; i++)
                if (bk_valid[i] && bk_side[i] != w.side && crosses(w.side, lim, bk_price[i]))
                    sum += bk_rem[i];
            if (sum < rem) begin
                push_status(w.id, lob_pkg::OUT_FOK_FAIL);
                return;
            end
        end
        k = 0;
        while (rem > 0 && k < lob_pkg::MAX_RESULTS) begin
            b = best_opposite(w.side, lim);
            if (b < 0) break;
            q = rem < bk_rem[b] ? rem : bk_rem[b];
            rem -= q;
            bk_rem[b] -= q;
            t = '0;
            t.tv = 1'b1;
            t.tp = bk_price[b];
            t.tq = q;
            t.rid = bk_id[b];
            t.iid = w.id;
            queue_expect(t);
            if (bk_rem[b] == 0) bk_valid[b] = 1'b0;
            k++;
        end
        oc = lob_pkg::OUT_FILLED;
        if (rem > 0 && w.kind != lob_pkg::KIND_FAK) begin
            f = -1;
            for (int i = 0; i < NORD; i++)
                if (f < 0 && !bk_valid[i]) f = i;
            if (f < 0) begin
                oc = lob_pkg::OUT_BOOK_FULL;
            end else begin
                bk_valid[f] = 1'b1;
                bk_id[f] = w.id;
                bk_side[f] = w.side;
                bk_price[f] = lim;
                bk_rem[f] = rem;
                bk_arr[f] = arr_cnt;
                arr_cnt++;
                oc = lob_pkg::OUT_RESTED;
            end
        end
        if (k == 0) begin
            push_status(w.id, oc);
        end else begin
            t = expected_trades.pop_back();
            t.outcome = oc;
            t.last = 1'b1;
            queue_expect(t);
        end
    endfunction

    function automatic t_order_word mk(logic mode, logic [31:0] id, logic side,
                                       logic [1:0] kind, logic [15:0] price,
                                       logic [31:0] qty);
        t_order_word w;
        w.mode = mode; w.id = id; w.side = side; w.kind = kind;
        w.price = price; w.qty = qty;
        return w;
    endfunction

    function automatic logic [1:0] rand_kind();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return lob_pkg::KIND_LIMIT;
        if (r < 7) return lob_pkg::KIND_MARKET;
        if (r < 9) return lob_pkg::KIND_FAK;
        return lob_pkg::KIND_FOK;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                match_order({i_mode, i_order_id, i_side, i_order_kind,
                             i_limit_price, i_quantity});
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (hold_send && (expected_trades.size() > 0 ||
                             (i_in_valid && o_in_ready))) begin
                    i_in_valid <= 1'b0;
                end else if (pending_orders.size() > 0) begin
                    if (!no_idle && $urandom_range(0, 7) == 0) begin
                        in_gap <= $urandom_range(1, 6) - 1;
                        i_in_valid <= 1'b0;
                    end else begin
                        automatic t_order_word w = pending_orders[0];
                        pending_orders.delete(0);
                        i_in_valid <= 1'b1;
                        {i_mode, i_order_id, i_side, i_order_kind,
                         i_limit_price, i_quantity} <= w;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_trades.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got iid=%h",
                             $time, o_incoming_id);
                    errors++;
                end else begin
                    automatic t_trade_word e = expected_trades[0];
                    automatic t_trade_word a = {o_trade_valid, o_trade_price,
                        o_trade_quantity, o_resting_id, o_incoming_id, o_outcome, o_last};
                    expected_trades.delete(0);
                    if (a.tv !== e.tv) begin
                        $display("%0t: trade_valid exp %h got %h", $time, e.tv, a.tv); errors++;
                    end
                    if (a.tp !== e.tp) begin
                        $display("%0t: trade_price exp %h got %h", $time, e.tp, a.tp); errors++;
                    end
                    if (a.tq !== e.tq) begin
                        $display("%0t: trade_quantity exp %h got %h", $time, e.tq, a.tq); errors++;
                    end
                    if (a.rid !== e.rid) begin
                        $display("%0t: resting_id exp %h got %h", $time, e.rid, a.rid); errors++;
                    end
                    if (a.iid !== e.iid) begin
                        $display("%0t: incoming_id exp %h got %h", $time, e.iid, a.iid); errors++;
                    end
                    if (a.outcome !== e.outcome) begin
                        $display("%0t: outcome exp %h got %h", $time, e.outcome, a.outcome); errors++;
                    end
                    if (a.last !== e.last) begin
                        $display("%0t: last exp %h got %h", $time, e.last, a.last); errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                out_gap <= $urandom_range(1, 6) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] ids[$];
        logic [31:0] id;
        logic [15:0] p;
        int n;
        for (int i = 0; i < NORD; i++) bk_valid[i] = 1'b0;
        arr_cnt = '0;

        // directed
        queue_order(mk(lob_pkg::MODE_ADD, 32'h1, lob_pkg::SIDE_BUY, lob_pkg::KIND_MARKET,
                       16'd5, 32'd10));
        queue_order(mk(lob_pkg::MODE_ADD, 32'h2, lob_pkg::SIDE_BUY, lob_pkg::KIND_FAK,
                       16'd5, 32'd10));
        queue_order(mk(lob_pkg::MODE_ADD, 32'h3, lob_pkg::SIDE_SELL, lob_pkg::KIND_LIMIT,
                       16'hFFFF, 32'hFFFF_FFFF));
        queue_order(mk(lob_pkg::MODE_ADD, 32'h4, lob_pkg::SIDE_SELL, lob_pkg::KIND_LIMIT,
                       16'd100, 32'd5));
        queue_order(mk(lob_pkg::MODE_ADD, 32'h5, lob_pkg::SIDE_SELL, lob_pkg::KIND_LIMIT,
                       16'd100, 32'd7));
        queue_order(mk(lob_pkg::MODE_ADD, 32'h4, lob_pkg::SIDE_BUY, lob_pkg::KIND_LIMIT,
                       16'd100, 32'd1));
        queue_order(mk(lob_pkg::MODE_ADD, 32'h6, lob_pkg::SIDE_BUY, lob_pkg::KIND_LIMIT,
                       16'd50, 32'd0));
        queue_order(mk(lob_pkg::MODE_ADD, 32'h7, lob_pkg::SIDE_BUY, lob_pkg::KIND_FOK,
                       16'd100, 32'd13));
        queue_order(mk(lob_pkg::MODE_ADD, 32'h8, lob_pkg::SIDE_BUY, lob_pkg::KIND_FOK,
                       16'd100, 32'd8));
        queue_order(mk(lob_pkg::MODE_ADD, 32'h9, lob_pkg::SIDE_BUY, lob_pkg::KIND_FAK,
                       16'd100, 32'd9));
        queue_order(mk(lob_pkg::MODE_ADD, 32'hA, lob_pkg::SIDE_BUY, lob_pkg::KIND_MARKET,
                       16'd0, 32'd20));
        queue_order(mk(lob_pkg::MODE_ADD, 32'hB, lob_pkg::SIDE_SELL, lob_pkg::KIND_MARKET,
                       16'd0, 32'd3));
        queue_order(mk(lob_pkg::MODE_ADD, 32'hFFFF_FFFF, lob_pkg::SIDE_BUY, lob_pkg::KIND_LIMIT,
                       16'd0, 32'd1));
        queue_order(mk(lob_pkg::MODE_CANCEL, 32'hFFFF_FFFF, lob_pkg::SIDE_SELL,
                       lob_pkg::KIND_FOK, 16'hFFFF, 32'd0));
        queue_order(mk(lob_pkg::MODE_CANCEL, 32'hFFFF_FFFF, lob_pkg::SIDE_BUY,
                       lob_pkg::KIND_LIMIT, 16'd0, 32'd1));
        queue_order(mk(lob_pkg::MODE_CANCEL, 32'h3, lob_pkg::SIDE_BUY, lob_pkg::KIND_LIMIT,
                       16'd0, 32'd1));
        queue_order(mk(lob_pkg::MODE_ADD, 32'h0, lob_pkg::SIDE_SELL, lob_pkg::KIND_FOK,
                       16'd0, 32'hFFFF_FFFF));
        // fill the book, then overflow it
        for (int i = 0; i < NORD + 2; i++)
            queue_order(mk(lob_pkg::MODE_ADD, 32'h100 + i, lob_pkg::SIDE_BUY,
                           lob_pkg::KIND_LIMIT, 16'd10, 32'd1));
        // sweep many resting orders at one price in one order
        queue_order(mk(lob_pkg::MODE_ADD, 32'h200, lob_pkg::SIDE_SELL, lob_pkg::KIND_LIMIT,
                       16'd0, 32'd70));

        // directed words go one at a time, each waiting for all of its results
        hold_send = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_sent();
        wait_drained();
        repeat (200) @(posedge i_clk);
        hold_send = 1'b0;

        // random: mostly small id pool, prices near mid, small quantities
        for (int i = 0; i < 400; i++) begin
            t_order_word w;
            if ($urandom_range(0, 3) == 0 || ids.size() == 0)
                id = $urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 200);
            else
                id = ids[$urandom_range(0, ids.size() - 1)];
            ids.push_back(id);
            if (ids.size() > 60) ids.delete(0);
            p = $urandom_range(0, 19) == 0 ? 16'($urandom) : 16'(1000 + $urandom_range(0, 12));
            n = $urandom_range(0, 19);
            w = mk($urandom_range(0, 5) == 0 ? lob_pkg::MODE_CANCEL : lob_pkg::MODE_ADD, id,
                   1'($urandom_range(0, 1)), rand_kind(), p,
                   n == 0 ? $urandom : (n == 1 ? 32'd0 : 32'($urandom_range(1, 30))));
            queue_order(w);
            if (i == 300) begin
                wait_sent();
                no_idle = 1'b1;
            end
        end
        wait_sent();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_trades.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
